@@ sv/etsyn_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package etsyn_pkg;

  // sizes
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int LENGTH_BITS      = 16;
  localparam int ADDR_W           = $clog2(SINE_TABLE_DEPTH);
  localparam int QTR              = SINE_TABLE_DEPTH / 4;
  localparam int QIDX_W           = ADDR_W - 1;
  localparam int MAG_W            = 15;
  localparam int WAVE_W           = 16;
  localparam int ENV_FRAC         = 16;
  localparam int ENV_W            = ENV_FRAC + 1;
  localparam int MIX_W            = 19;
  localparam int MUL_A_W          = 36;
  localparam int MUL_B_W          = ENV_W + 1;
  localparam int MUL_P_W          = MUL_A_W + MUL_B_W;
  localparam int PROD_W           = 44;
  localparam int SCALE_W          = PROD_W + 6;
  localparam int SCALE_SHIFT      = 40;
  localparam int DIV_CNT_W        = $clog2(ENV_FRAC + 1);
  localparam int SERIES_TERMS     = 10;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [ENV_W-1:0] ENV_UNITY = ENV_W'(1) << ENV_FRAC;
  localparam logic signed [PROD_W-1:0] DEN = PROD_W'(64'd5 << 39);
  localparam logic [7:0] IDLE_SAMPLE = 8'd127;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_START = 1'b1
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOK1,
    S_LOOK2,
    S_ENV,
    S_DIV,
    S_MUL1,
    S_MUL2,
    S_CLAMP,
    S_BYTE,
    S_EMIT
  } state_t;

  // divider request and response
  typedef struct packed {
    logic                   start;
    logic [LENGTH_BITS-1:0] dividend;
    logic [LENGTH_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [ENV_FRAC-1:0] quot;
  } div_rsp_t;

  typedef logic [MAG_W-1:0] qsine_t [0:QTR];

  // sin(x) on [0, pi/2] by taylor series, x and result in Q2.30
  function automatic logic [63:0] quarter_sine(input logic [63:0] x);
    logic [63:0] term;
    logic [63:0] sum;
    term = x;
    sum  = x;
    for (int n = 1; n <= SERIES_TERMS; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 64'((2 * n) * (2 * n + 1));
      if ((n & 1) == 1) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  // quarter wave magnitudes, entry j is the table value at j / depth of a turn
  function automatic qsine_t build_qsine();
    qsine_t      tbl;
    logic [63:0] x;
    logic [63:0] mag;
    for (int j = 0; j <= QTR; j++) begin
      x   = (64'(4 * j) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
      mag = (quarter_sine(x) * 64'd32767 + (64'd1 << 29)) >> 30;
      if (mag > 64'd32767) begin
        mag = 64'd32767;
      end
      tbl[j] = MAG_W'(mag);
    end
    return tbl;
  endfunction

  localparam qsine_t QSINE = build_qsine();

  // full wave lookup from the top bits of a phase, folded onto the quarter table
  function automatic logic signed [WAVE_W-1:0] wave_at(input logic [31:0] p);
    logic [ADDR_W-1:0] idx;
    logic [QIDX_W-1:0] low;
    logic [QIDX_W-1:0] j;
    logic [MAG_W-1:0]  mag;
    idx = p[31 -: ADDR_W];
    low = QIDX_W'(idx[ADDR_W-3:0]);
    j   = idx[ADDR_W-2] ? QIDX_W'(QTR) - low : low;
    mag = QSINE[j];
    return idx[ADDR_W-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

endpackage

`default_nettype wire

@@ sv/enveloped_tone_synth_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Tone generator: a start word loads phase step, note length, fade length and
// volume and gives no output; each tick word gives one unsigned 8-bit sample
// (sine plus 0.2 of the second harmonic, shaped by a linear fade in and out,
// scaled by volume). A tick with no note playing gives 127. Inside a fade the
// envelope comes from a 16-step serial divider; the other steps share one
// multiplier (envelope, then volume) and one sine table port (fundamental,
// then harmonic). The input is stalled while a tick is being worked on. A
// finished sample sits in the output register, so the next word is taken
// while it waits.

module enveloped_tone_synth_top import etsyn_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        command,
  input  wire logic [31:0] phase_step,
  input  wire logic [15:0] note_length,
  input  wire logic [15:0] fade_length,
  input  wire logic [7:0]  volume,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       sample,
  output logic             last,
  output logic             playing
);

  state_t                    state;
  state_t                    state_next;
  logic [31:0]               phase_acc;
  logic [31:0]               note_step;
  logic [LENGTH_BITS-1:0]    sample_index;
  logic [LENGTH_BITS-1:0]    note_samples;
  logic [LENGTH_BITS-1:0]    fade_samples;
  logic [7:0]                gain;
  logic                      active;
  logic signed [WAVE_W-1:0]  s1;
  logic signed [MIX_W-1:0]   mix;
  logic [ENV_W-1:0]          env;
  logic signed [PROD_W-1:0]  acc;
  logic [7:0]                res_sample;
  logic                      res_last;
  logic                      res_playing;

  logic                      accept;
  logic                      out_free;
  logic                      need_div;
  logic [LENGTH_BITS-1:0]    env_num;
  logic [LENGTH_BITS:0]      i_plus_f;
  logic [31:0]               lut_phase;
  logic signed [WAVE_W-1:0]  lut_val;
  logic signed [MIX_W-1:0]   mix_next;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  logic signed [PROD_W-1:0]  clamped;
  logic [SCALE_W-1:0]        t_ext;
  logic [SCALE_W-1:0]        scaled;
  logic [LENGTH_BITS:0]      i_inc;
  logic                      is_last;
  logic                      past_end;
  div_req_t                  div_req;
  div_rsp_t                  div_rsp;

  etsyn_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // envelope select: ramp up, ramp down or unity
  always_comb begin
    i_plus_f = {1'b0, sample_index} + {1'b0, fade_samples};
    need_div = 1'b0;
    env_num  = sample_index;
    if ((i_plus_f > {1'b0, note_samples}) && (fade_samples != '0)) begin
      need_div = 1'b1;
      env_num  = (note_samples >= sample_index) ? note_samples - sample_index : '0;
    end else if (sample_index < fade_samples) begin
      need_div = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && (command == CMD_TICK)) begin
          state_next = active ? S_LOOK1 : S_EMIT;
        end
      end
      S_LOOK1: state_next = S_LOOK2;
      S_LOOK2: state_next = S_ENV;
      S_ENV:   state_next = need_div ? S_DIV : S_MUL1;
      S_DIV: begin
        if (div_rsp.done) begin
          state_next = S_MUL1;
        end
      end
      S_MUL1:  state_next = S_MUL2;
      S_MUL2:  state_next = S_CLAMP;
      S_CLAMP: state_next = S_BYTE;
      S_BYTE:  state_next = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs: handshake, divider kick, shared table and multiplier operands
  always_comb begin
    in_stall         = (state != S_IDLE);
    div_req.start    = (state == S_ENV) && need_div;
    div_req.dividend = env_num;
    div_req.divisor  = fade_samples;
    lut_phase        = (state == S_LOOK2) ? {phase_acc[30:0], 1'b0} : phase_acc;
    if (state == S_MUL1) begin
      mul_a = MUL_A_W'(mix);
      mul_b = $signed({1'b0, env});
    end else begin
      mul_a = acc[MUL_A_W-1:0];
      mul_b = $signed(MUL_B_W'(gain));
    end
  end

  // shared table port, mix and multiplier
  always_comb begin
    lut_val  = wave_at(lut_phase);
    mix_next = (MIX_W'(s1) <<< 2) + MIX_W'(s1) + MIX_W'(lut_val);
    mul_p    = mul_a * mul_b;
  end

  // clamp to +-1 and map to a byte: byte = (v + den) * 51 / 2^40
  always_comb begin
    if (acc > DEN) begin
      clamped = DEN;
    end else if (acc < -DEN) begin
      clamped = -DEN;
    end else begin
      clamped = acc;
    end
    t_ext    = SCALE_W'($unsigned(acc));
    scaled   = (t_ext << 5) + (t_ext << 4) + (t_ext << 1) + t_ext;
    i_inc    = {1'b0, sample_index} + (LENGTH_BITS + 1)'(1);
    is_last  = (i_inc == {1'b0, note_samples});
    past_end = (i_inc > {1'b0, note_samples});
  end

  // control and note state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      active       <= 1'b0;
      phase_acc    <= '0;
      note_step    <= '0;
      sample_index <= '0;
      note_samples <= '0;
      fade_samples <= '0;
      gain         <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && (command == CMD_START)) begin
        phase_acc    <= '0;
        note_step    <= phase_step;
        sample_index <= '0;
        note_samples <= LENGTH_BITS'(note_length);
        fade_samples <= LENGTH_BITS'(fade_length);
        gain         <= volume;
        active       <= (LENGTH_BITS'(note_length) != '0);
      end else if (accept && active) begin
        phase_acc <= phase_acc + note_step;
      end
      if (state == S_BYTE) begin
        sample_index <= LENGTH_BITS'(i_inc);
        if (is_last || past_end) begin
          active <= 1'b0;
        end
      end
      if ((state == S_EMIT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept && (command == CMD_TICK) && !active) begin
          res_sample  <= IDLE_SAMPLE;
          res_last    <= 1'b0;
          res_playing <= 1'b0;
        end
      end
      S_LOOK1: s1  <= lut_val;
      S_LOOK2: mix <= mix_next;
      S_ENV: begin
        if (!need_div) begin
          env <= ENV_UNITY;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          env <= {1'b0, div_rsp.quot};
        end
      end
      S_MUL1:  acc <= mul_p[PROD_W-1:0];
      S_MUL2:  acc <= mul_p[PROD_W-1:0];
      S_CLAMP: acc <= clamped + DEN;
      S_BYTE: begin
        res_sample  <= scaled[SCALE_SHIFT +: 8];
        res_last    <= is_last;
        res_playing <= 1'b1;
      end
      S_EMIT: begin
        if (out_free) begin
          sample  <= res_sample;
          last    <= res_last;
          playing <= res_playing;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

@@ sv/etsyn_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

module etsyn_div import etsyn_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic                   busy;
  logic                   done;
  logic [DIV_CNT_W-1:0]   cnt;
  logic [LENGTH_BITS-1:0] rem;
  logic [LENGTH_BITS-1:0] dvs;
  logic [ENV_FRAC-1:0]    quot;
  logic [LENGTH_BITS:0]   rem2;
  logic                   fits;

  // one restoring step: shift remainder, trial subtract
  always_comb begin
    rem2 = {rem, 1'b0};
    fits = rem2 >= {1'b0, dvs};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == DIV_CNT_W'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(ENV_FRAC);
      end else if (busy) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // datapath, dividend is below divisor so quotient has ENV_FRAC bits
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= req.dividend;
      dvs  <= req.divisor;
      quot <= '0;
    end else if (busy) begin
      rem  <= fits ? LENGTH_BITS'(rem2 - {1'b0, dvs}) : LENGTH_BITS'(rem2);
      quot <= {quot[ENV_FRAC-2:0], fits};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

`default_nettype wire

@@ sv/etsyn_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module etsyn_checker import etsyn_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        command,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [7:0]  sample,
  input wire logic        last,
  input wire logic        playing
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sample) && $stable(last)
      && $stable(playing))
    else $error("output word changed while stalled");

  // a word outside a note is silence
  a_idle_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && !playing |-> (sample == IDLE_SAMPLE) && !last)
    else $error("idle word is not silence");

  // the final sample belongs to a note
  a_last_playing: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> playing)
    else $error("last flagged outside a note");

  // a tick occupies the block
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (command == CMD_TICK) |=> in_stall)
    else $error("input not stalled after a tick");

  // a start word leaves the input free in the next cycle
  a_start_ready: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (command == CMD_START) |=> !in_stall)
    else $error("input stalled after a start word");

endmodule

bind enveloped_tone_synth_top etsyn_checker u_etsyn_checker (.*);

`default_nettype wire

@@ bench/tone_checker.sv @@
`timescale 1ns / 1ps

module tone_checker import etsyn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        command,
  input  logic [31:0] phase_step,
  input  logic [15:0] note_length,
  input  logic [15:0] fade_length,
  input  logic [7:0]  volume,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  sample,
  input  logic        last,
  input  logic        playing,
  output int          mismatches,
  output int          pending_words,
  output int          samples_checked,
  output int          note_ends
);

  typedef struct packed {
    logic [7:0] sample;
    logic       last;
    logic       playing;
  } tone_word_t;

  // full scale of mix * envelope * gain
  localparam longint SCALE_DEN = 5 * (longint'(1) << 39);

  int         sine_lut [SINE_TABLE_DEPTH];
  tone_word_t expected_words [$];

  // tone state
  logic [31:0]            tone_phase;
  logic [31:0]            tone_step;
  logic [LENGTH_BITS-1:0] tone_index;
  logic [LENGTH_BITS-1:0] tone_len;
  logic [LENGTH_BITS-1:0] tone_fade;
  logic [7:0]             tone_gain;
  logic                   tone_on;

  initial begin
    mismatches      = 0;
    pending_words   = 0;
    samples_checked = 0;
    note_ends       = 0;
  end

  // sin on a quarter turn, argument and result in Q2.30
  function automatic longint unsigned taylor_quarter(input longint unsigned x);
    longint unsigned term;
    longint unsigned sum;
    term = x;
    sum  = x;
    for (int k = 1; k <= 10; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        sum = (sum >= term) ? sum - term : 0;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  // full sine table, Q1.15
  initial begin : build_lut
    longint unsigned four_k;
    longint unsigned quad;
    longint unsigned rem;
    longint unsigned part;
    longint unsigned arg;
    longint unsigned mag;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      four_k = 4 * k;
      quad   = four_k / SINE_TABLE_DEPTH;
      rem    = four_k - quad * SINE_TABLE_DEPTH;
      part   = quad[0] ? SINE_TABLE_DEPTH - rem : rem;
      arg    = (part * HALF_PI_Q30) / SINE_TABLE_DEPTH;
      mag    = (taylor_quarter(arg) * 32767 + (64'd1 << 29)) >> 30;
      if (mag > 32767) begin
        mag = 32767;
      end
      sine_lut[k] = (quad >= 2) ? -int'(mag) : int'(mag);
    end
  end

  function automatic int lookup_sine(input logic [31:0] p);
    return sine_lut[p[31 -: ADDR_W]];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("tone_checker: %s", msg);
    mismatches++;
  endtask

  // next sample of the tone for one tick word
  task automatic predict_tick(output tone_word_t w);
    longint unsigned idx;
    longint unsigned len;
    longint unsigned fade;
    longint unsigned env;
    longint          mix;
    longint          num;
    longint          level;
    if (!tone_on) begin
      // silence while idle, state untouched
      w.sample  = IDLE_SAMPLE;
      w.last    = 1'b0;
      w.playing = 1'b0;
    end else begin
      tone_phase = tone_phase + tone_step;
      idx  = tone_index;
      len  = tone_len;
      fade = tone_fade;
      // linear fade in and fade out, zero fade leaves unity
      env = 65536;
      if (idx < fade) begin
        env = (idx * 65536) / fade;
      end
      if (idx + fade > len && fade != 0) begin
        env = (((len >= idx) ? len - idx : 0) * 65536) / fade;
      end
      // fundamental plus a fifth of the second harmonic, in fifths
      mix = 5 * lookup_sine(tone_phase) + lookup_sine({tone_phase[30:0], 1'b0});
      num = mix * longint'(env) * longint'(tone_gain);
      if (num > SCALE_DEN) begin
        num = SCALE_DEN;
      end
      if (num < -SCALE_DEN) begin
        num = -SCALE_DEN;
      end
      level = ((num + SCALE_DEN) * 255) / (2 * SCALE_DEN);
      if (level > 255) begin
        level = 255;
      end
      w.sample  = level[7:0];
      w.last    = (idx + 1 == len);
      w.playing = 1'b1;
      tone_index = LENGTH_BITS'(idx + 1);
      if (idx + 1 >= len) begin
        tone_on = 1'b0;
      end
    end
  endtask

  // watch both channels, oldest expectation first
  always @(posedge clk) begin : watch
    tone_word_t want;
    tone_word_t got;
    if (rst) begin
      tone_phase = '0;
      tone_step  = '0;
      tone_index = '0;
      tone_len   = '0;
      tone_fade  = '0;
      tone_gain  = '0;
      tone_on    = 1'b0;
      expected_words.delete();
      pending_words = 0;
    end else begin
      // result side
      if (out_valid && !out_stall) begin
        got = {sample, last, playing};
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word sample=%0d last=%0b playing=%0b",
                                    sample, last, playing));
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            report_mismatch($sformatf(
              "word %0d: sample %0d/%0d last %0b/%0b playing %0b/%0b (got/want)",
              samples_checked, got.sample, want.sample, got.last, want.last,
              got.playing, want.playing));
          end
          samples_checked++;
          if (want.last) begin
            note_ends++;
          end
        end
      end
      // input side
      if (in_valid && !in_stall) begin
        if (command == CMD_START) begin
          tone_phase = '0;
          tone_step  = phase_step;
          tone_index = '0;
          tone_len   = LENGTH_BITS'(note_length);
          tone_fade  = LENGTH_BITS'(fade_length);
          tone_gain  = volume;
          tone_on    = (LENGTH_BITS'(note_length) != 0);
        end else begin
          predict_tick(want);
          expected_words.insert(expected_words.size(), want);
        end
      end
      pending_words = expected_words.size();
    end
  end

endmodule

@@ bench/enveloped_tone_synth_top_tb.sv @@
`timescale 1ns / 1ps

module enveloped_tone_synth_top_tb;
  import etsyn_pkg::*;

  localparam int RANDOM_WORDS = 1650;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 40;
  localparam int LIMIT_NS     = 8000000;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_BEAT
  } stall_mode_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        command;
  logic [31:0] phase_step;
  logic [15:0] note_length;
  logic [15:0] fade_length;
  logic [7:0]  volume;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  sample;
  logic        last;
  logic        playing;

  int mismatches;
  int pending_words;
  int samples_checked;
  int note_ends;

  int words_sent = 0;
  int burst_left = 0;
  int hold_asks  = 0;
  int hold_done  = 0;

  enveloped_tone_synth_top DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .phase_step  (phase_step),
    .note_length (note_length),
    .fade_length (fade_length),
    .volume      (volume),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sample      (sample),
    .last        (last),
    .playing     (playing)
  );

  tone_checker CHECK (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .command         (command),
    .phase_step      (phase_step),
    .note_length     (note_length),
    .fade_length     (fade_length),
    .volume          (volume),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .sample          (sample),
    .last            (last),
    .playing         (playing),
    .mismatches      (mismatches),
    .pending_words   (pending_words),
    .samples_checked (samples_checked),
    .note_ends       (note_ends)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #LIMIT_NS;
    $display("enveloped_tone_synth_top_tb: FAIL");
    $finish;
  end

  // receiver: stall pattern changes over time, long hold-off on request
  initial begin : receiver
    stall_mode_t mode;
    int          mode_left;
    int          beat;
    out_stall = 1'b0;
    mode      = STALL_NONE;
    mode_left = 0;
    beat      = 0;
    forever begin
      @(negedge clk);
      if (hold_asks != hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done++;
      end else begin
        if (mode_left == 0) begin
          mode      = stall_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(40, 300);
        end
        mode_left--;
        beat++;
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 4) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= (beat % 3 == 0);
        endcase
      end
    end
  end

  // offer one word, sender may idle between bursts
  task automatic send_word(input cmd_t c, input logic [31:0] step, input logic [15:0] len,
                           input logic [15:0] fade, input logic [7:0] vol);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid    <= 1'b1;
    command     <= c;
    phase_step  <= step;
    note_length <= len;
    fade_length <= fade;
    volume      <= vol;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_tick();
    send_word(CMD_TICK, $urandom, 16'($urandom), 16'($urandom), 8'($urandom));
  endtask

  // hold the input until every sample is out, then let the block settle
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_words != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    burst_left = 0;
  endtask

  // one note with random content, mostly played to its end
  task automatic play_random_note();
    int unsigned len_v;
    int unsigned fade_v;
    int unsigned ticks;
    int unsigned pick;
    logic [31:0] step_v;
    logic [7:0]  vol_v;
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      len_v = $urandom_range(1, 40);
    end else if (pick == 7) begin
      len_v = 0;
    end else if (pick == 8) begin
      len_v = $urandom_range(41, 300);
    end else begin
      len_v = $urandom_range(301, 65535);
    end
    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      fade_v = 0;
    end else if (pick < 7) begin
      fade_v = $urandom_range(1, len_v / 2 + 1);
    end else if (pick < 9) begin
      fade_v = $urandom_range(0, len_v + 4);
    end else begin
      fade_v = $urandom_range(0, 65535);
    end
    pick = $urandom_range(0, 7);
    if (pick == 0) begin
      step_v = 32'h8000_0000;
    end else if (pick == 1) begin
      step_v = $urandom_range(0, 255);
    end else begin
      step_v = $urandom;
    end
    pick = $urandom_range(0, 7);
    if (pick < 2) begin
      vol_v = 8'd255;
    end else if (pick == 2) begin
      vol_v = 8'd0;
    end else begin
      vol_v = 8'($urandom_range(0, 255));
    end
    send_word(CMD_START, step_v, 16'(len_v), 16'(fade_v), vol_v);
    // long notes are cut short by the next start
    if (len_v > 300) begin
      ticks = $urandom_range(1, 50);
    end else if ($urandom_range(0, 6) == 0) begin
      ticks = $urandom_range(0, len_v);
    end else begin
      ticks = len_v + $urandom_range(0, 2);
    end
    repeat (ticks) send_tick();
  endtask

  // stimulus and verdict
  initial begin : stimulus
    int target;
    bit first_hold;
    bit second_hold;
    bit mid_drain;
    rst         = 1'b1;
    in_valid    = 1'b0;
    command     = CMD_TICK;
    phase_step  = '0;
    note_length = '0;
    fade_length = '0;
    volume      = '0;
    first_hold  = 1'b0;
    second_hold = 1'b0;
    mid_drain   = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // idle tick, then a zero length note stays idle
    send_tick();
    send_word(CMD_START, 32'h0000_0000, 16'd0, 16'd0, 8'd0);
    send_tick();
    // half turn step, no fade, full volume, played past its end
    send_word(CMD_START, 32'h8000_0000, 16'd3, 16'd0, 8'd255);
    repeat (4) send_tick();
    // wrapping step, widest fade, cut short by a new start
    send_word(CMD_START, 32'hFFFF_FFFF, 16'd4, 16'hFFFF, 8'd128);
    repeat (3) send_tick();
    send_word(CMD_START, 32'h0123_4567, 16'd6, 16'd2, 8'd255);
    repeat (6) send_tick();
    // longest note with longest fade, smallest nonzero volume
    send_word(CMD_START, 32'h0400_0000, 16'hFFFF, 16'hFFFF, 8'd1);
    repeat (2) send_tick();
    // zero volume note, then idle again
    send_word(CMD_START, 32'h2000_0000, 16'd2, 16'd1, 8'd0);
    repeat (3) send_tick();
    drain_results();

    // random notes with pressure points along the way
    target = words_sent + RANDOM_WORDS;
    while (words_sent < target) begin
      if (!first_hold && words_sent >= target - RANDOM_WORDS + 500) begin
        hold_asks++;
        first_hold = 1'b1;
      end
      if (!mid_drain && words_sent >= target - RANDOM_WORDS + 850) begin
        drain_results();
        mid_drain = 1'b1;
      end
      if (!second_hold && words_sent >= target - RANDOM_WORDS + 1200) begin
        hold_asks++;
        second_hold = 1'b1;
      end
      play_random_note();
    end
    drain_results();

    $display("summary: %0d words sent, %0d samples checked, %0d note ends, %0d output holds",
             words_sent, samples_checked, note_ends, hold_done);
    if (mismatches == 0) begin
      $display("enveloped_tone_synth_top_tb: PASS");
    end else begin
      $display("enveloped_tone_synth_top_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/etsyn_pkg.sv
sv/etsyn_div.sv
sv/enveloped_tone_synth_top.sv
sv/etsyn_checker.sv
bench/tone_checker.sv
bench/enveloped_tone_synth_top_tb.sv
